@@ design/chs_pkg.sv @@
`timescale 1ns / 1ps

package chs_pkg;

  typedef struct packed {
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
  } chs_in_t;

  typedef struct packed {
    logic signed [15:0] smooth_x;
    logic signed [15:0] smooth_y;
    logic signed [15:0] heading;
    logic               accepted;
  } chs_out_t;

  typedef enum logic [1:0] {
    REG_OFFSET_X   = 2'd0,
    REG_OFFSET_Y   = 2'd1,
    REG_GATE_LIMIT = 2'd2
  } chs_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_DIVW,
    S_PREP,
    S_ROT,
    S_FIN
  } chs_state_t;

  localparam logic [14:0] GATE_RESET = 15'd500;

  // 2^18 / 5 rounded up; exact quotient for any dividend below 2^18.
  localparam logic [15:0] RECIP5 = 16'd52429;

  localparam int ATAN_ENTRIES = 24;
  localparam int ATAN_IDX_W   = 5;
  localparam int X_W          = 28;
  localparam int Z_W          = 34;

  localparam logic signed [Z_W-1:0] PI_Q30 = 34'sd3373259426;

  function automatic logic signed [Z_W-1:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      5'd0:    v = 34'sh03243F6A8;
      5'd1:    v = 34'sh01DAC6705;
      5'd2:    v = 34'sh00FADBAFC;
      5'd3:    v = 34'sh007F56EA6;
      5'd4:    v = 34'sh003FEAB76;
      5'd5:    v = 34'sh001FFD55B;
      5'd6:    v = 34'sh000FFFAAA;
      5'd7:    v = 34'sh0007FFF55;
      5'd8:    v = 34'sh0003FFFEA;
      5'd9:    v = 34'sh0001FFFFD;
      5'd10:   v = 34'sh0000FFFFF;
      5'd11:   v = 34'sh00007FFFF;
      5'd12:   v = 34'sh00003FFFF;
      5'd13:   v = 34'sh00001FFFF;
      5'd14:   v = 34'sh00000FFFF;
      5'd15:   v = 34'sh000007FFF;
      5'd16:   v = 34'sh000003FFF;
      5'd17:   v = 34'sh000001FFF;
      5'd18:   v = 34'sh000000FFF;
      5'd19:   v = 34'sh0000007FF;
      5'd20:   v = 34'sh0000003FF;
      5'd21:   v = 34'sh0000001FF;
      5'd22:   v = 34'sh0000000FF;
      5'd23:   v = 34'sh00000007F;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Rounds a Q30 angle to a fixed point angle with sh fewer fraction bits.
  function automatic logic signed [Z_W-1:0] to_angle(input logic signed [Z_W-1:0] z,
                                                      input int sh);
    logic signed [Z_W-1:0] half;
    half = Z_W'(64'd1 << (sh - 1));
    return (z + half) >>> sh;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
    logic signed [15:0] r;
    if (v > 17'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -17'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

@@ design/compass_heading_smoother_core.sv @@
`timescale 1ns / 1ps

// Compass heading smoother. Each transfer on the input channel carries one raw X/Y
// magnetometer sample; the block adds the per-axis calibration offsets, seeds the
// smoothing filter with the first sample after reset and afterwards folds in only
// samples whose corrected axes both lie within plus or minus gate_limit, moving each
// smoothed axis one fifth of the way toward the sample. Every sample yields exactly one
// result with the smoothed pair, an accepted flag and the heading atan2(y, x) in radians
// with ANGLE_FRAC_BITS fraction bits. A sample that updates the filter passes from its
// input transfer through the check, the divide for each axis, the set-up, the rotation
// and the final state back to idle while the output register is free: a rotation
// stage performs one CORDIC iteration per cycle, and the divide by five runs one axis
// at a time through a single multiplier. A seeding or gated-out sample skips the divide,
// and a zero vector skips the rotation.
// A sample whose result is done may wait in the output register while the next sample is
// taken in; if that result is still waiting when the next one is ready, the block holds
// in its last state until the waiting result's transfer. Configuration writes are
// accepted in any cycle and must only be issued while no sample is in flight.
module compass_heading_smoother_core
  import chs_pkg::*;
#(
  parameter int CORDIC_STEPS    = 16,
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  chs_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output chs_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int ROT_STEPS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
  localparam int IW        = $clog2(ROT_STEPS);
  localparam int SH        = 30 - ANGLE_FRAC_BITS;
  localparam logic signed [Z_W-1:0] ANGLE_LIM = to_angle(PI_Q30, SH);

  chs_state_t state, state_next;

  logic signed [15:0] offset_x;
  logic signed [15:0] offset_y;
  logic [14:0]        gate_limit;
  logic signed [15:0] filt_x;
  logic signed [15:0] filt_y;
  logic               seeded;
  logic               accepted;

  logic signed [16:0] cx;
  logic signed [16:0] cy;
  logic               axis;
  logic [33:0]        prod;
  logic               prod_neg;

  logic signed [X_W-1:0] x;
  logic signed [X_W-1:0] y;
  logic signed [Z_W-1:0] z;
  logic [IW-1:0]         i;

  logic                  fin_load;

  // Gate test.
  logic signed [16:0] gate_pos;
  logic signed [16:0] gate_neg;
  logic               in_gate;

  // Divide by five of c + 4*filt for the selected axis.
  logic signed [16:0] div_c;
  logic signed [15:0] div_f;
  logic signed [18:0] div_sum;
  logic signed [18:0] div_sum_neg;
  logic [17:0]        div_mag;
  logic [15:0]        quot;
  logic signed [16:0] quot_s;
  logic signed [15:0] quot_sat;

  // CORDIC set-up and one rotation.
  logic                  pre_zero;
  logic                  pre_neg;
  logic signed [16:0]    ext_x;
  logic signed [16:0]    ext_y;
  logic signed [16:0]    ax;
  logic signed [16:0]    ay;
  logic signed [X_W-1:0] rot_dx;
  logic signed [X_W-1:0] rot_dy;
  logic signed [Z_W-1:0] rot_atan;
  logic                  rot_last;

  logic signed [Z_W-1:0] ang;
  logic signed [Z_W-1:0] ang_clamped;

  assign gate_pos = signed'({2'b00, gate_limit});
  assign gate_neg = -gate_pos;
  assign in_gate  = (cx >= gate_neg) && (cx <= gate_pos) &&
                    (cy >= gate_neg) && (cy <= gate_pos);

  assign div_c       = axis ? cy : cx;
  assign div_f       = axis ? filt_y : filt_x;
  assign div_sum     = {{2{div_c[16]}}, div_c} + {div_f[15], div_f, 2'b00};
  assign div_sum_neg = -div_sum;
  assign div_mag     = div_sum[18] ? div_sum_neg[17:0] : div_sum[17:0];
  assign quot        = prod[33:18];
  assign quot_s      = prod_neg ? -signed'({1'b0, quot}) : signed'({1'b0, quot});
  assign quot_sat    = sat16(quot_s);

  assign pre_zero = (filt_x == 16'sd0) && (filt_y == 16'sd0);
  assign pre_neg  = filt_x[15];
  assign ext_x    = {filt_x[15], filt_x};
  assign ext_y    = {filt_y[15], filt_y};
  assign ax       = pre_neg ? -ext_x : ext_x;
  assign ay       = pre_neg ? -ext_y : ext_y;

  assign rot_dx   = y >>> i;
  assign rot_dy   = x >>> i;
  assign rot_atan = atan_q30(ATAN_IDX_W'(i));
  assign rot_last = (i == IW'(ROT_STEPS - 1));

  assign ang         = to_angle(z, SH);
  assign ang_clamped = (ang > ANGLE_LIM) ? ANGLE_LIM :
                       (ang < -ANGLE_LIM) ? -ANGLE_LIM : ang;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_CHECK;
      S_CHECK: state_next = (seeded && in_gate) ? S_DIV : S_PREP;
      S_DIV:   state_next = S_DIVW;
      S_DIVW:  state_next = axis ? S_PREP : S_DIV;
      S_PREP:  state_next = pre_zero ? S_FIN : S_ROT;
      S_ROT:   if (rot_last) state_next = S_FIN;
      S_FIN:   if (fin_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == S_IDLE);
    cfg_ready = 1'b1;
    fin_load  = (state == S_FIN) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      offset_x   <= '0;
      offset_y   <= '0;
      gate_limit <= GATE_RESET;
      filt_x     <= '0;
      filt_y     <= '0;
      seeded     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_valid) begin
        if (cfg_index == REG_OFFSET_X) begin
          offset_x <= cfg_data;
        end else if (cfg_index == REG_OFFSET_Y) begin
          offset_y <= cfg_data;
        end else if (cfg_index == REG_GATE_LIMIT) begin
          gate_limit <= cfg_data[14:0];
        end
      end

      if (fin_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cx <= {in_data.raw_x[15], in_data.raw_x} + {offset_x[15], offset_x};
            cy <= {in_data.raw_y[15], in_data.raw_y} + {offset_y[15], offset_y};
          end
        end
        S_CHECK: begin
          axis <= 1'b0;
          if (!seeded) begin
            filt_x   <= sat16(cx);
            filt_y   <= sat16(cy);
            seeded   <= 1'b1;
            accepted <= 1'b1;
          end else begin
            accepted <= in_gate;
          end
        end
        S_DIV: begin
          prod     <= 34'(div_mag) * 34'(RECIP5);
          prod_neg <= div_sum[18];
        end
        S_DIVW: begin
          if (axis) begin
            filt_y <= quot_sat;
          end else begin
            filt_x <= quot_sat;
          end
          axis <= ~axis;
        end
        S_PREP: begin
          i <= '0;
          x <= {{(X_W - 25){ax[16]}}, ax, 8'h00};
          y <= {{(X_W - 25){ay[16]}}, ay, 8'h00};
          if (pre_zero || !pre_neg) begin
            z <= '0;
          end else begin
            z <= filt_y[15] ? -PI_Q30 : PI_Q30;
          end
        end
        S_ROT: begin
          // The sign of y picks the rotation direction; both updates use the old x and y.
          if (!y[X_W-1]) begin
            x <= x + rot_dx;
            y <= y - rot_dy;
            z <= z + rot_atan;
          end else begin
            x <= x - rot_dx;
            y <= y + rot_dy;
            z <= z - rot_atan;
          end
          i <= i + 1'b1;
        end
        S_FIN: begin
          if (fin_load) begin
            out_data.smooth_x <= filt_x;
            out_data.smooth_y <= filt_y;
            out_data.heading  <= ang_clamped[15:0];
            out_data.accepted <= accepted;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ design/chs_checker.sv @@
`timescale 1ns / 1ps

module chs_checker
  import chs_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = 13
) (
  input logic     clk,
  input logic     rst,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input chs_out_t out_data
);

  localparam logic signed [Z_W-1:0] LIM_Z = to_angle(PI_Q30, 30 - ANGLE_FRAC_BITS);
  localparam logic signed [15:0]    LIM   = LIM_Z[15:0];

  logic               have_prev;
  logic signed [15:0] last_x;
  logic signed [15:0] last_y;
  logic signed [15:0] last_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
    end else if (out_valid && out_ready) begin
      have_prev <= 1'b1;
      last_x    <= out_data.smooth_x;
      last_y    <= out_data.smooth_y;
      last_h    <= out_data.heading;
    end
  end

  // The block works on one sample at a time.
  a_busy_after_input: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a sample is in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped before its transfer");

  // A gated-out sample leaves the filter, and so the heading, untouched.
  a_gated_repeats: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.accepted && have_prev |->
      out_data.smooth_x == last_x && out_data.smooth_y == last_y &&
      out_data.heading == last_h)
    else $error("gated-out sample changed the smoothed state");

  a_zero_heading: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.smooth_x == 16'sd0 && out_data.smooth_y == 16'sd0 |->
      out_data.heading == 16'sd0)
    else $error("zero vector gave a nonzero heading");

  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.heading <= LIM && out_data.heading >= -LIM)
    else $error("heading outside plus or minus pi");

endmodule

bind compass_heading_smoother_core chs_checker #(
  .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
) u_chs_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

@@ dv/tb_compass_heading_smoother_core.sv @@
`timescale 1ns / 1ps

localparam int HDG_STEPS = 16;
localparam int HDG_FRAC = 13;
localparam int HDG_SHIFT = 30 - HDG_FRAC;
localparam int GATE_AT_RESET = 500;
localparam longint PI_Q30_TB = 64'sd3373259426;

class compass_scoreboard;
  int off_x;
  int off_y;
  int gate;
  int fx;
  int fy;
  bit seeded;
  int errors;
  chs_pkg::chs_out_t readings_q[$];

  function new();
    off_x = 0;
    off_y = 0;
    gate = GATE_AT_RESET;
    fx = 0;
    fy = 0;
    seeded = 1'b0;
    errors = 0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [15:0] d);
    case (idx)
      chs_pkg::REG_OFFSET_X: off_x = int'($signed(d));
      chs_pkg::REG_OFFSET_Y: off_y = int'($signed(d));
      chs_pkg::REG_GATE_LIMIT: gate = int'(d[14:0]);
      default: ;
    endcase
  endfunction

  function int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // atan(2^-i) in Q30, truncated.
  function longint atan_entry(int i);
    case (i)
      0: return 64'h3243F6A8;
      1: return 64'h1DAC6705;
      2: return 64'h0FADBAFC;
      3: return 64'h07F56EA6;
      4: return 64'h03FEAB76;
      5: return 64'h01FFD55B;
      6: return 64'h00FFFAAA;
      7: return 64'h007FFF55;
      8: return 64'h003FFFEA;
      9: return 64'h001FFFFD;
      10: return 64'h000FFFFF;
      11: return 64'h0007FFFF;
      12: return 64'h0003FFFF;
      13: return 64'h0001FFFF;
      14: return 64'h0000FFFF;
      15: return 64'h00007FFF;
      16: return 64'h00003FFF;
      17: return 64'h00001FFF;
      18: return 64'h00000FFF;
      19: return 64'h000007FF;
      20: return 64'h000003FF;
      21: return 64'h000001FF;
      22: return 64'h000000FF;
      23: return 64'h0000007F;
      default: return 64'h0;
    endcase
  endfunction

  function int to_q13(longint z);
    longint half;
    half = longint'(1) <<< (HDG_SHIFT - 1);
    return int'((z + half) >>> HDG_SHIFT);
  endfunction

  function int atan2_q13(int hx, int hy);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    int a;
    int lim;
    if (hx == 0 && hy == 0) return 0;
    x = hx;
    y = hy;
    z = 0;
    // Left half plane: rotate by pi first so the iterations converge.
    if (x < 0) begin
      z = (y >= 0) ? PI_Q30_TB : -PI_Q30_TB;
      x = -x;
      y = -y;
    end
    x = x * 256;
    y = y * 256;
    for (int i = 0; i < HDG_STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + atan_entry(i);
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - atan_entry(i);
      end
    end
    a = to_q13(z);
    lim = to_q13(PI_Q30_TB);
    if (a > lim) a = lim;
    if (a < -lim) a = -lim;
    return a;
  endfunction

  function void take_sample(chs_pkg::chs_in_t s);
    int cx;
    int cy;
    int hdg;
    bit acc;
    chs_pkg::chs_out_t r;
    cx = int'(s.raw_x) + off_x;
    cy = int'(s.raw_y) + off_y;
    acc = 1'b0;
    if (!seeded) begin
      fx = clamp16(cx);
      fy = clamp16(cy);
      seeded = 1'b1;
      acc = 1'b1;
    end else if (cx >= -gate && cx <= gate && cy >= -gate && cy <= gate) begin
      fx = clamp16((cx + 4 * fx) / 5);
      fy = clamp16((cy + 4 * fy) / 5);
      acc = 1'b1;
    end
    hdg = atan2_q13(fx, fy);
    r.smooth_x = fx[15:0];
    r.smooth_y = fy[15:0];
    r.heading = hdg[15:0];
    r.accepted = acc;
    readings_q.push_back(r);
  endfunction

  function int outstanding();
    return readings_q.size();
  endfunction

  function void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  function void match_reading(chs_pkg::chs_out_t got);
    chs_pkg::chs_out_t want;
    if (readings_q.size() == 0) begin
      $display("%0t: output with nothing outstanding, actual x %0d y %0d heading %0d acc %0d",
               $time, got.smooth_x, got.smooth_y, got.heading, got.accepted);
      errors++;
      return;
    end
    want = readings_q.pop_front();
    check_field("smooth_x", int'(want.smooth_x), int'(got.smooth_x));
    check_field("smooth_y", int'(want.smooth_y), int'(got.smooth_y));
    check_field("heading", int'(want.heading), int'(got.heading));
    check_field("accepted", int'(want.accepted), int'(got.accepted));
  endfunction
endclass

module tb_compass_heading_smoother_core;
  import chs_pkg::*;

  typedef enum {PICK_INSIDE, PICK_EDGE, PICK_NEAR_ZERO, PICK_ANY} pick_t;

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 220;
  localparam int SETTLE_CYCLES = 40;
  localparam int WATCHDOG_LIMIT = 4000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  chs_in_t in_data;
  logic out_valid;
  logic out_ready;
  chs_out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;

  bit calm = 1'b0;
  int idle_run = 0;
  compass_scoreboard sb;

  compass_heading_smoother_core #(
    .CORDIC_STEPS(HDG_STEPS),
    .ANGLE_FRAC_BITS(HDG_FRAC)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, d);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_xy(input logic signed [15:0] x, input logic signed [15:0] y);
    chs_in_t s;
    int gap;
    s.raw_x = x;
    s.raw_y = y;
    @(negedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    do @(posedge clk); while (!in_ready);
    sb.take_sample(s);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Corrected target value for one axis, turned back into a raw sample.
  function automatic logic signed [15:0] pick_axis(pick_t kind, int off);
    int g;
    int c;
    g = sb.gate;
    case (kind)
      PICK_INSIDE: c = int'($urandom_range(0, 2 * g + 4)) - (g + 2);
      PICK_EDGE: begin
        case ($urandom_range(0, 3))
          0: c = -g - 1;
          1: c = -g;
          2: c = g;
          default: c = g + 1;
        endcase
      end
      PICK_NEAR_ZERO: c = int'($urandom_range(0, 16)) - 8;
      default: return 16'($urandom);
    endcase
    return 16'(sb.clamp16(c - off));
  endfunction

  function automatic pick_t pick_kind();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return PICK_INSIDE;
    if (r == 6) return PICK_EDGE;
    if (r == 7) return PICK_NEAR_ZERO;
    return PICK_ANY;
  endfunction

  // Raw value that pulls a smoothed axis at f straight to zero, within the gate.
  function automatic logic signed [15:0] toward_zero(int f);
    int c;
    c = -4 * f;
    if (c > 32767) c = 32767;
    if (c < -32767) c = -32767;
    return 16'(c);
  endfunction

  initial begin : rx_side
    int hold;
    hold = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        hold = $urandom_range(0, 3);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.match_reading(out_data);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_run <= 0;
    end else begin
      idle_run <= idle_run + 1;
    end
    if (idle_run == WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    int k;
    pick_t kind;
    logic [14:0] g;
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_OFFSET_X;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The seeding sample ignores the gate and saturates both corrected axes.
    write_reg(REG_OFFSET_X, 16'h7FFF);
    write_reg(REG_OFFSET_Y, 16'h8000);
    write_reg(REG_SPARE, 16'hFFFF);
    send_xy(16'sh7FFF, 16'sh8000);
    send_xy(0, 0);
    drain_results();

    // Gate boundaries at the reset limit.
    write_reg(REG_OFFSET_X, 16'h0000);
    write_reg(REG_OFFSET_Y, 16'h0000);
    send_xy(500, -500);
    send_xy(501, 0);
    send_xy(0, -501);
    send_xy(-500, 500);
    drain_results();

    // Wide gate: walk the filter to the zero vector, then around the quadrants.
    write_reg(REG_GATE_LIMIT, 16'h7FFF);
    k = 0;
    while ((sb.fx != 0 || sb.fy != 0) && k < 10) begin
      send_xy(toward_zero(sb.fx), toward_zero(sb.fy));
      k++;
    end
    send_xy(-5, 0);
    send_xy(4, -5);
    send_xy(5, 4);
    send_xy(-9, 5);
    send_xy(4, -10);
    send_xy(32767, 32767);
    send_xy(-32768, 0);
    send_xy(-32767, -32767);

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      case (p)
        0: begin
          write_reg(REG_OFFSET_X, 16'h0000);
          write_reg(REG_OFFSET_Y, 16'h0000);
          write_reg(REG_GATE_LIMIT, 16'h7FFF);
        end
        1: begin
          write_reg(REG_OFFSET_X, 16'h8000);
          write_reg(REG_OFFSET_Y, 16'h7FFF);
          write_reg(REG_GATE_LIMIT, 16'h7FFF);
        end
        2: begin
          write_reg(REG_OFFSET_X, 16'($urandom));
          write_reg(REG_OFFSET_Y, 16'($urandom));
          write_reg(REG_GATE_LIMIT, 16'h0000);
        end
        3: begin
          write_reg(REG_OFFSET_X, 16'h7FFF);
          write_reg(REG_OFFSET_Y, 16'h8000);
          write_reg(REG_GATE_LIMIT, 16'd500);
        end
        default: begin
          write_reg(REG_OFFSET_X, 16'($urandom));
          write_reg(REG_OFFSET_Y, 16'($urandom));
          g = ($urandom_range(0, 1) == 1) ? 15'($urandom_range(0, 32767))
                                          : 15'($urandom_range(0, 64));
          // The top data bit has no register behind it.
          write_reg(REG_GATE_LIMIT, {1'($urandom), g});
        end
      endcase
      if (p == PHASES - 1) calm = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 4 && n == PHASE_ITEMS / 2) drain_results();
        kind = pick_kind();
        send_xy(pick_axis(kind, sb.off_x), pick_axis(kind, sb.off_y));
      end
    end

    drain_results();
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
